@@ design/sts_pkg.sv @@
// Shared types and constants for the stereo transient shaper.
// No dependencies; imported by sts_seq, the top level and the bench.
package sts_pkg;

  localparam int TILT_FRAC   = 23;  // tilt coefficient is signed over 2^23
  localparam int TILT_COEF_W = 24;
  localparam int TILT_POLE_W = 26;  // 2^23 +/- coef needs two more bits
  localparam int REG_IDX_W   = 3;

  // envelope reset values over 2^24, rescaled at the top level; tilt coefficient over 2^23
  localparam logic [23:0] RST_ATTACK_FAST   = 24'd530542;
  localparam logic [23:0] RST_ATTACK_SLOW   = 24'd530542;
  localparam logic [23:0] RST_ATTACK_HOLD   = 24'd16770537;
  localparam logic [23:0] RST_RELEASE_ATT   = 24'd667917;
  localparam logic [23:0] RST_RELEASE_FAST  = 24'd16776685;
  localparam logic [23:0] RST_RELEASE_SLOW  = 24'd16776685;
  localparam logic [23:0] RST_TILT_COEF     = 24'd8237613;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ATTACK_FAST         = 3'd0,
    REG_ATTACK_SLOW         = 3'd1,
    REG_ATTACK_HOLD_RELEASE = 3'd2,
    REG_RELEASE_ATTACK      = 3'd3,
    REG_RELEASE_FAST        = 3'd4,
    REG_RELEASE_SLOW        = 3'd5,
    REG_TILT_COEF           = 3'd6,
    REG_TILT_HIGH_MODE      = 3'd7
  } sts_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TL_FB,
    ST_TL_IN,
    ST_TR_FB,
    ST_TR_IN,
    ST_ENV0,
    ST_ENV1,
    ST_ENV2,
    ST_ENV3,
    ST_ENV_LAST,
    ST_GAIN,
    ST_OUT_L,
    ST_OUT_R,
    ST_RND_R,
    ST_DONE
  } step_e;

  typedef struct packed {
    logic in_valid;
    logic out_stall;
  } sts_stat_t;

  typedef struct packed {
    step_e step;
    logic  in_ready;
    logic  finish;
  } sts_ctrl_t;

endpackage

@@ design/sts_if.sv @@
// Stream channels of the transient shaper: input pair and result pair.
// Standalone; width follows the sample width of the block.
interface sts_in_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] left_sample;
  logic [W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sts_out_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] left_result;
  logic [W-1:0] right_result;

  modport source (output valid, output left_result, output right_result, input ready);
  modport sink   (input valid, input left_result, input right_result, output ready);
endinterface

@@ design/sts_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on nothing; used by the top level for every product.
module sts_mul #(
  parameter int W = 29
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*W)'(a_i) * (2*W)'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ design/sts_seq.sv @@
// Step sequencer: walks one sample pair through the shared multiplier.
// Depends on sts_pkg (step_e, sts_stat_t, sts_ctrl_t).
module sts_seq
  import sts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sts_stat_t stat_i,
  output sts_ctrl_t ctrl_o
);

  step_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl_o.step     = state_q;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.finish   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_valid) state_d = ST_TL_FB;
      end
      ST_TL_FB:    state_d = ST_TL_IN;
      ST_TL_IN:    state_d = ST_TR_FB;
      ST_TR_FB:    state_d = ST_TR_IN;
      ST_TR_IN:    state_d = ST_ENV0;
      ST_ENV0:     state_d = ST_ENV1;
      ST_ENV1:     state_d = ST_ENV2;
      ST_ENV2:     state_d = ST_ENV3;
      ST_ENV3:     state_d = ST_ENV_LAST;
      ST_ENV_LAST: state_d = ST_GAIN;
      ST_GAIN:     state_d = ST_OUT_L;
      ST_OUT_L:    state_d = ST_OUT_R;
      ST_OUT_R:    state_d = ST_RND_R;
      ST_RND_R:    state_d = ST_DONE;
      ST_DONE: begin
        // hold the last step until the result register is free
        if (!stat_i.out_stall) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

endmodule

@@ design/stereo_transient_shaper.sv @@
// Stereo transient shaper top level: registers, datapath and result register.
// Depends on sts_pkg, sts_if (channels), sts_mul and sts_seq.
//
//  channel   dir  handshake        beat contents
//  in_i      in   valid / ready    left_sample, right_sample
//  out_o     out  valid / ready    left_result, right_result
//  cfg       in   cfg_we_i only    cfg_index_i, cfg_data_i
//
// A pair is accepted in the idle step and then walks through 14 steps of the shared
// multiplier (ten products, each registered, then folded into state).
// Reset clears the tilt states and envelopes and loads coefficient defaults.
// The last step waits while a previous result is still held in the output
// register; a new input beat is taken only in the idle step.
module stereo_transient_shaper
  import sts_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24,
  localparam int CfgW = (COEF_FRAC_BITS > TILT_COEF_W) ? COEF_FRAC_BITS : TILT_COEF_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sts_in_if.sink               in_i,
  sts_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CF  = COEF_FRAC_BITS;
  localparam int TB  = SB + 4;          // tilt state
  localparam int EB  = SB + 2;          // envelope
  localparam int GB  = SB + 4;          // gain
  localparam int XB  = TB + 1;          // filtered plus dry
  localparam int MW0 = (XB > CF + 1) ? XB : CF + 1;
  localparam int MW  = (MW0 > TILT_POLE_W) ? MW0 : TILT_POLE_W;
  localparam int PW  = 2 * MW;
  localparam int AW  = PW + 1;
  localparam int TSW = AW - TILT_FRAC;
  localparam int OSW = AW - SB + 1;
  localparam int SHL = (CF >= 24) ? CF - 24 : 0;
  localparam int SHR = (CF >= 24) ? 0 : 24 - CF;

  localparam logic signed [TILT_POLE_W-1:0] TILT_ONE = TILT_POLE_W'(64'sd1 <<< TILT_FRAC);
  localparam logic signed [AW-1:0]  RND_TILT = AW'(64'sd1 <<< (TILT_FRAC - 1));
  localparam logic signed [AW-1:0]  RND_OUT  = AW'(64'sd1 <<< (SB - 2));
  localparam logic signed [TSW-1:0] T_MAX = TSW'((64'sd1 <<< (TB - 1)) - 64'sd1);
  localparam logic signed [TSW-1:0] T_MIN = TSW'(-(64'sd1 <<< (TB - 1)));
  localparam logic signed [OSW:0]   O_MAX = (OSW + 1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [OSW:0]   O_MIN = (OSW + 1)'(-(64'sd1 <<< (SB - 1)));

  function automatic logic [CF-1:0] scale_rst(input logic [23:0] v);
    logic [63:0] w;
    w = (64'(v) << SHL) >> SHR;
    return w[CF-1:0];
  endfunction

  // configuration
  logic [CF-1:0]          att_fast_q, att_slow_q, att_hold_q;
  logic [CF-1:0]          rel_att_q, rel_fast_q, rel_slow_q;
  logic signed [TILT_COEF_W-1:0] tilt_coef_q;
  logic                   tilt_hi_q;

  // state
  logic signed [TB-1:0]   fbl_q, fbr_q;
  logic [EB-1:0]          env_q [4];
  logic                   out_valid_q;

  // working registers
  logic signed [SB-1:0]   a_q, b_q;
  logic [EB-1:0]          lvl_q;
  logic signed [AW-1:0]   acc_q;
  logic signed [XB-1:0]   e_q, f_q;
  logic signed [GB-1:0]   g_q;
  logic                   up_q;
  logic [1:0]             envk_q;
  logic [EB-1:0]          env_old_q;
  logic signed [SB-1:0]   yl_q, left_q, right_q;

  sts_stat_t stat;
  sts_ctrl_t ctrl;

  logic signed [MW-1:0]   op_a, op_b;
  logic signed [PW-1:0]   p;
  logic signed [AW-1:0]   p_ext;

  sts_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (p)
  );

  assign stat.in_valid  = in_i.valid;
  assign stat.out_stall = out_valid_q & ~out_o.ready;

  sts_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_i.ready         = ctrl.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.left_result  = left_q;
  assign out_o.right_result = right_q;

  logic accept;
  assign accept = in_i.valid & ctrl.in_ready;

  // tilt pole coefficients
  logic signed [TILT_POLE_W-1:0] fi, fo;
  assign fi = TILT_POLE_W'(tilt_coef_q);
  assign fo = tilt_hi_q ? (TILT_ONE + fi) : (TILT_ONE - fi);

  // level |left + right|
  logic signed [SB:0] pair_sum;
  logic [SB:0]        pair_abs;
  assign pair_sum = (SB + 1)'(a_q) + (SB + 1)'(b_q);
  assign pair_abs = pair_sum[SB] ? (SB + 1)'(-pair_sum) : pair_sum;

  // envelope issue side
  logic [1:0]    env_ia;
  logic [EB-1:0] env_rd, env_diff;
  logic [CF-1:0] att_sel, dec_sel;
  logic          env_up;

  always_comb begin
    case (ctrl.step)
      ST_ENV1: env_ia = 2'd1;
      ST_ENV2: env_ia = 2'd2;
      ST_ENV3: env_ia = 2'd3;
      default: env_ia = 2'd0;
    endcase
  end

  always_comb begin
    case (env_ia)
      2'd0:    begin att_sel = att_fast_q; dec_sel = att_hold_q; end
      2'd1:    begin att_sel = att_slow_q; dec_sel = att_hold_q; end
      2'd2:    begin att_sel = rel_att_q;  dec_sel = rel_fast_q; end
      default: begin att_sel = rel_att_q;  dec_sel = rel_slow_q; end
    endcase
  end

  assign env_rd   = env_q[env_ia];
  assign env_up   = lvl_q > env_rd;
  assign env_diff = lvl_q - env_rd;

  // multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.step)
      ST_TL_FB: begin op_a = MW'(fo); op_b = MW'(fbl_q); end
      ST_TL_IN: begin op_a = MW'(fi); op_b = MW'(a_q);   end
      ST_TR_FB: begin op_a = MW'(fo); op_b = MW'(fbr_q); end
      ST_TR_IN: begin op_a = MW'(fi); op_b = MW'(b_q);   end
      ST_ENV0, ST_ENV1, ST_ENV2, ST_ENV3: begin
        op_a = env_up ? signed'(MW'(att_sel))  : signed'(MW'(dec_sel));
        op_b = env_up ? signed'(MW'(env_diff)) : signed'(MW'(env_rd));
      end
      ST_OUT_L: begin op_a = MW'(e_q); op_b = MW'(g_q); end
      ST_OUT_R: begin op_a = MW'(f_q); op_b = MW'(g_q); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign p_ext = AW'(p);

  // tilt update: floor shift then saturate to the state width
  logic signed [AW-1:0]  tilt_sum;
  logic signed [TSW-1:0] tilt_sh;
  logic signed [TB-1:0]  tilt_new;
  assign tilt_sum = acc_q + p_ext;
  assign tilt_sh  = tilt_sum[AW-1:TILT_FRAC];
  always_comb begin
    if (tilt_sh > T_MAX)      tilt_new = TB'(T_MAX);
    else if (tilt_sh < T_MIN) tilt_new = TB'(T_MIN);
    else                      tilt_new = tilt_sh[TB-1:0];
  end

  // envelope consume side
  logic [EB-1:0] env_step, env_new;
  assign env_step = p[CF +: EB];
  assign env_new  = up_q ? (env_old_q + env_step) : env_step;

  // output: input plus rounded product, saturated
  logic signed [SB-1:0]  out_src;
  logic signed [OSW:0]   out_sum;
  logic signed [SB-1:0]  out_sat;
  assign out_src = (ctrl.step == ST_RND_R) ? a_q : b_q;
  assign out_sum = (OSW + 1)'(out_src) + (OSW + 1)'(signed'(acc_q[AW-1:SB-1]));
  always_comb begin
    if (out_sum > O_MAX)      out_sat = SB'(O_MAX);
    else if (out_sum < O_MIN) out_sat = SB'(O_MIN);
    else                      out_sat = out_sum[SB-1:0];
  end

  // registers, configuration and filter/envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_fast_q  <= scale_rst(RST_ATTACK_FAST);
      att_slow_q  <= scale_rst(RST_ATTACK_SLOW);
      att_hold_q  <= scale_rst(RST_ATTACK_HOLD);
      rel_att_q   <= scale_rst(RST_RELEASE_ATT);
      rel_fast_q  <= scale_rst(RST_RELEASE_FAST);
      rel_slow_q  <= scale_rst(RST_RELEASE_SLOW);
      tilt_coef_q <= RST_TILT_COEF;
      tilt_hi_q   <= 1'b0;
      fbl_q       <= '0;
      fbr_q       <= '0;
      for (int k = 0; k < 4; k++) env_q[k] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ATTACK_FAST:         att_fast_q  <= cfg_data_i[CF-1:0];
          REG_ATTACK_SLOW:         att_slow_q  <= cfg_data_i[CF-1:0];
          REG_ATTACK_HOLD_RELEASE: att_hold_q  <= cfg_data_i[CF-1:0];
          REG_RELEASE_ATTACK:      rel_att_q   <= cfg_data_i[CF-1:0];
          REG_RELEASE_FAST:        rel_fast_q  <= cfg_data_i[CF-1:0];
          REG_RELEASE_SLOW:        rel_slow_q  <= cfg_data_i[CF-1:0];
          REG_TILT_COEF:           tilt_coef_q <= cfg_data_i[TILT_COEF_W-1:0];
          REG_TILT_HIGH_MODE:      tilt_hi_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (ctrl.step)
        ST_TR_FB: fbl_q <= tilt_new;
        ST_ENV0:  fbr_q <= tilt_new;
        ST_ENV1, ST_ENV2, ST_ENV3, ST_ENV_LAST: env_q[envk_q] <= env_new;
        default: ;
      endcase
      if (ctrl.finish)       out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= signed'(in_i.left_sample);
      b_q <= signed'(in_i.right_sample);
    end
    case (ctrl.step)
      ST_TL_FB: lvl_q <= EB'(pair_abs);
      ST_TL_IN: acc_q <= p_ext + RND_TILT;
      ST_TR_IN: begin
        acc_q <= p_ext + RND_TILT;
        e_q   <= XB'(fbl_q) + (tilt_hi_q ? XB'(a_q) : XB'(0));
      end
      ST_GAIN: g_q <= GB'(env_q[0]) - GB'(env_q[1]) + GB'(env_q[2]) - GB'(env_q[3]);
      ST_OUT_R: acc_q <= p_ext + RND_OUT;
      ST_RND_R: begin
        yl_q  <= out_sat;
        acc_q <= p_ext + RND_OUT;
      end
      default: ;
    endcase
    if (ctrl.step == ST_ENV1) f_q <= XB'(fbr_q) + (tilt_hi_q ? XB'(b_q) : XB'(0));
    if (ctrl.step == ST_ENV0 || ctrl.step == ST_ENV1 || ctrl.step == ST_ENV2 ||
        ctrl.step == ST_ENV3) begin
      up_q      <= env_up;
      envk_q    <= env_ia;
      env_old_q <= env_rd;
    end
    if (ctrl.finish) begin
      left_q  <= yl_q;
      right_q <= out_sat;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for stereo_transient_shaper: drives sample pairs and register
// writes, predicts each shaped pair and compares it with the result stream.
// Depends on sts_pkg, sts_if (channels) and the design files under design/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam logic [23:0] S_MAX   = 24'h7FFFFF;
  localparam logic [23:0] S_MIN   = 24'h800000;
  localparam logic [23:0] S_ZERO  = 24'h000000;
  localparam logic [23:0] S_ONE   = 24'h000001;
  localparam logic [23:0] S_M_ONE = 24'hFFFFFF;
  localparam longint      ENV_MAX = (longint'(1) << 26) - 1;
  localparam int          MAX_GAP = 30;
  localparam int          BURST_PAIRS = 75;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
  } stereo_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  sts_in_if  #(.W(24)) in_ch ();
  sts_out_if #(.W(24)) out_ch ();

  stereo_transient_shaper DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register mirror
  logic [23:0] att_fast, att_slow, hold_rel, rel_att, rel_fast, rel_slow, tilt_fi;
  logic        tilt_high;
  // filter and envelope state mirror
  longint tilt_fb_l, tilt_fb_r;
  longint env_lvl[4];

  stereo_pair_t shaped_pairs_due[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic longint clamp_signed(longint v, int w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint tilt_next(longint fb, longint x, longint fo, longint fi);
    longint acc;
    acc = fo * fb + fi * x + (longint'(1) << 22);
    return clamp_signed(acc >>> 23, 28);
  endfunction

  function automatic longint env_next(longint env, longint lvl, longint att, longint dec);
    longint nxt;
    if (lvl > env) nxt = env + ((att * (lvl - env)) >>> 24);
    else nxt = (env * dec) >>> 24;
    if (nxt > ENV_MAX) nxt = ENV_MAX;
    return nxt;
  endfunction

  // advances the mirrored state by one pair and returns the shaped pair
  function automatic stereo_pair_t shape_pair(logic [23:0] l, logic [23:0] r);
    longint a, b, fi, fo, e, f, lvl, gain, yl, yr;
    stereo_pair_t res;
    a  = longint'($signed(l));
    b  = longint'($signed(r));
    fi = longint'($signed(tilt_fi));
    fo = tilt_high ? (longint'(1) << 23) + fi : (longint'(1) << 23) - fi;
    tilt_fb_l = tilt_next(tilt_fb_l, a, fo, fi);
    tilt_fb_r = tilt_next(tilt_fb_r, b, fo, fi);
    e = tilt_fb_l + (tilt_high ? a : 0);
    f = tilt_fb_r + (tilt_high ? b : 0);
    lvl = a + b;
    if (lvl < 0) lvl = -lvl;
    env_lvl[0] = env_next(env_lvl[0], lvl, longint'(att_fast), longint'(hold_rel));
    env_lvl[1] = env_next(env_lvl[1], lvl, longint'(att_slow), longint'(hold_rel));
    env_lvl[2] = env_next(env_lvl[2], lvl, longint'(rel_att), longint'(rel_fast));
    env_lvl[3] = env_next(env_lvl[3], lvl, longint'(rel_att), longint'(rel_slow));
    gain = env_lvl[0] - env_lvl[1] + env_lvl[2] - env_lvl[3];
    yl = clamp_signed(a + ((e * gain + (longint'(1) << 22)) >>> 23), 24);
    yr = clamp_signed(b + ((f * gain + (longint'(1) << 22)) >>> 23), 24);
    res.left  = yl[23:0];
    res.right = yr[23:0];
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    stereo_pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (shaped_pairs_due.size() == 0) begin
        note_mismatch($sformatf("result beat with none pending: left %0d right %0d",
                                $signed(out_ch.left_result), $signed(out_ch.right_result)));
      end else begin
        want = shaped_pairs_due.pop_front();
        if (out_ch.left_result !== want.left)
          note_mismatch($sformatf("left_result expected %0d got %0d",
                                  $signed(want.left), $signed(out_ch.left_result)));
        if (out_ch.right_result !== want.right)
          note_mismatch($sformatf("right_result expected %0d got %0d",
                                  $signed(want.right), $signed(out_ch.right_result)));
      end
    end
  end

  task automatic send_pair(logic [23:0] l, logic [23:0] r);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    shaped_pairs_due.push_back(shape_pair(l, r));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (shaped_pairs_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(sts_reg_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_ATTACK_FAST:         att_fast  = val;
      REG_ATTACK_SLOW:         att_slow  = val;
      REG_ATTACK_HOLD_RELEASE: hold_rel  = val;
      REG_RELEASE_ATTACK:      rel_att   = val;
      REG_RELEASE_FAST:        rel_fast  = val;
      REG_RELEASE_SLOW:        rel_slow  = val;
      REG_TILT_COEF:           tilt_fi   = val;
      REG_TILT_HIGH_MODE:      tilt_high = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [23:0] af, logic [23:0] as, logic [23:0] hr,
                                logic [23:0] ra, logic [23:0] rf, logic [23:0] rs,
                                logic [23:0] tc, logic [23:0] hm);
    stop_sending();
    wait_for_results();
    write_reg(REG_ATTACK_FAST, af);
    write_reg(REG_ATTACK_SLOW, as);
    write_reg(REG_ATTACK_HOLD_RELEASE, hr);
    write_reg(REG_RELEASE_ATTACK, ra);
    write_reg(REG_RELEASE_FAST, rf);
    write_reg(REG_RELEASE_SLOW, rs);
    write_reg(REG_TILT_COEF, tc);
    write_reg(REG_TILT_HIGH_MODE, hm);
  endtask

  function automatic logic [23:0] scaled_sample(int k);
    logic signed [23:0] v;
    v = 24'($urandom);
    return v >>> (23 - k);
  endfunction

  function automatic logic [23:0] extreme_sample();
    case ($urandom_range(4))
      0: return S_MAX;
      1: return S_MIN;
      2: return S_ZERO;
      3: return S_ONE;
      default: return S_M_ONE;
    endcase
  endfunction

  // bursts of related pairs so the envelopes see real attacks and releases
  task automatic send_random_pairs(int count);
    int burst_left, k, form;
    logic [23:0] l, r;
    burst_left = 0;
    k = 0;
    form = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        k = $urandom_range(0, 23);
        form = $urandom_range(0, 5);
      end
      burst_left--;
      case (form)
        0: begin l = scaled_sample(k); r = scaled_sample(k); end
        1: begin l = scaled_sample(k); r = l; end
        2: begin l = scaled_sample(k); r = -l; end   // cancels: level near zero
        3: begin l = extreme_sample(); r = extreme_sample(); end
        4: begin l = 24'($urandom); r = 24'($urandom); end
        default: begin l = scaled_sample($urandom_range(0, 2)); r = scaled_sample(0); end
      endcase
      send_pair(l, r);
    end
  endtask

  task automatic test_directed_pairs();
    send_pair(S_ZERO, S_ZERO);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MAX, S_ZERO);
    send_pair(S_ZERO, S_MIN);
    send_pair(S_M_ONE, S_M_ONE);
    send_pair(S_ONE, S_M_ONE);
    send_pair(S_ONE, S_ONE);
    // loud step then silence: attack followed by release
    repeat (4) send_pair(S_MAX, S_MAX);
    repeat (6) send_pair(S_ZERO, S_ZERO);
  endtask

  task automatic test_extreme_high_coefs();
    // high mode, upper data bits set to check only bit 0 counts
    write_all_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, S_MAX, 24'hFFFFFF);
    send_random_pairs(BURST_PAIRS);
  endtask

  task automatic test_extreme_low_coefs();
    // pole of 2 in low mode: tilt state runs into saturation
    write_all_regs(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, S_MIN, 24'hFFFFFE);
    send_random_pairs(BURST_PAIRS);
  endtask

  task automatic test_transient_gain();
    // fast envelopes track, slow ones hold: large gain drives output saturation
    write_all_regs(24'hFFFFFF, 24'h0, 24'($urandom), 24'($urandom), 24'h0, 24'hFFFFFF,
                   24'($urandom), 24'($urandom));
    send_random_pairs(BURST_PAIRS);
  endtask

  task automatic test_random_coefs();
    write_all_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    send_random_pairs(BURST_PAIRS);
  endtask

  initial begin
    int regime;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    out_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_ATTACK_FAST;
    cfg_data_i         = '0;
    att_fast  = RST_ATTACK_FAST;
    att_slow  = RST_ATTACK_SLOW;
    hold_rel  = RST_ATTACK_HOLD;
    rel_att   = RST_RELEASE_ATT;
    rel_fast  = RST_RELEASE_FAST;
    rel_slow  = RST_RELEASE_SLOW;
    tilt_fi   = RST_TILT_COEF;
    tilt_high = 1'b0;
    tilt_fb_l = 0;
    tilt_fb_r = 0;
    foreach (env_lvl[i]) env_lvl[i] = 0;
    send_idle_pct = 11;
    recv_idle_pct = 65;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_pairs();
    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin send_idle_pct = 11; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      test_extreme_high_coefs();
      test_extreme_low_coefs();
      test_transient_gain();
      test_random_coefs();
    end

    stop_sending();
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ stereo_transient_shaper.f @@
design/sts_pkg.sv
design/sts_if.sv
design/sts_mul.sv
design/sts_seq.sv
design/stereo_transient_shaper.sv
sim/tb_top.sv
